### src/tra_pkg.sv
// Package for the task run-time accounting block: item kinds, controller
// states, command/status structs. No dependencies.
package tra_pkg;

	localparam int TASK_SLOTS_DEF = 16;
	localparam logic [6:0] PERCENT = 7'd100;

	typedef enum logic [2:0] {
		K_REGISTER = 3'd0,
		K_READY    = 3'd1,
		K_RUN_BEG  = 3'd2,
		K_RUN_END  = 3'd3,
		K_SNAPSHOT = 3'd4,
		K_RESET    = 3'd5,
		K_IDLE_Q   = 3'd6,
		K_NONE     = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CLOSE,
		ST_EMIT,
		ST_EMPTY,
		ST_CLEAR,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_OUT
	} state_t;

	typedef struct packed {
		logic load;       // capture input item
		logic do_reg;     // register handle
		logic run_beg;    // set run start
		logic srch_init;  // reset search pointer
		logic srch_step;  // compare one slot
		logic set_ready;  // mark found slot ready
		logic close;      // charge run to found slot
		logic emit_init;  // reset emit pointer
		logic emit_step;  // present one entry, advance
		logic emit_empty; // empty snapshot answer
		logic clr;        // clear interval
		logic div_init;
		logic div_step;
		logic div_out;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  srch_done;  // search finished
		logic  emit_done;  // last entry presented
		logic  empty;      // no tasks
		logic  div_done;
	} stat_t;

endpackage

### src/tra_ctrl.sv
// Controller state machine for task run-time accounting.
// Depends on tra_pkg.
module tra_ctrl import tra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				// the search pointer is reset with the load; simple kinds are dispatched here
				unique case (st.kind)
					K_REGISTER: begin
						cmd.do_reg = 1'b1;
						state_d = ST_IDLE;
					end
					K_RUN_BEG: begin
						cmd.run_beg = 1'b1;
						state_d = ST_IDLE;
					end
					K_IDLE_Q: state_d = ST_DIV_INIT;
					K_NONE: state_d = ST_IDLE;
					default: begin
						cmd.srch_step = 1'b1;
						if (st.srch_done) state_d = ST_CLOSE;
					end
				endcase
			end
			ST_CLOSE: begin
				unique case (st.kind)
					K_READY: begin
						cmd.set_ready = 1'b1;
						state_d = ST_IDLE;
					end
					K_RUN_END: begin
						cmd.close = 1'b1;
						state_d = ST_IDLE;
					end
					K_SNAPSHOT: begin
						cmd.close = 1'b1;
						cmd.emit_init = 1'b1;
						state_d = st.empty ? ST_EMPTY : ST_EMIT;
					end
					default: begin
						cmd.close = 1'b1;
						state_d = ST_CLEAR;
					end
				endcase
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (st.emit_done) state_d = ST_CLEAR;
			end
			ST_EMPTY: begin
				cmd.emit_empty = 1'b1;
				state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) state_d = ST_DIV_OUT;
			end
			ST_DIV_OUT: begin
				cmd.div_out = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.srch_init = cmd.load;
	end

endmodule

### src/tra_dp.sv
// Datapath for task run-time accounting: task table, accumulators, slot
// search, snapshot emitter and restoring divider. Depends on tra_pkg.
module tra_dp import tra_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [2:0]  kind,
	input  logic [31:0] task_handle,
	input  logic [31:0] timestamp,
	output logic        strobe,
	output logic [3:0]  entry_index,
	output logic [31:0] entry_handle,
	output logic [63:0] run_total,
	output logic [31:0] worst_delay,
	output logic [31:0] interval_begin,
	output logic [31:0] snapshot_time,
	output logic [6:0]  idle_percent,
	output logic        entry_valid,
	output logic        last
);

	localparam int IW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam logic [CW-1:0] CAP = CW'(TASK_SLOTS - 1);

	logic [31:0] handle_q [TASK_SLOTS];
	logic [63:0] total_q  [TASK_SLOTS];
	logic [31:0] rstamp_q [TASK_SLOTS];
	logic [31:0] worst_q  [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] marked_q;
	logic [CW-1:0] count_q;
	logic [31:0] run_start_q, idle_sum_q, ivl_start_q, last_q_q;

	kind_t       kind_q;
	logic [31:0] hdl_q, now_q;
	logic [CW-1:0] ptr_q;
	logic        found_q;
	logic [IW-1:0] slot_q;

	// divider: quotient of idle*100 (39 bits) by diff (32 bits)
	logic [38:0] dividend_q;
	logic [38:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] divisor_q;
	logic [5:0]  dcnt_q;
	logic        dzero_q;

	logic [31:0] elapsed;
	logic [31:0] delay;
	logic [IW-1:0] ptr_idx;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        ptr_end;

	assign ptr_idx = ptr_q[IW-1:0];
	assign ptr_end = (ptr_q >= count_q);
	assign elapsed = now_q - run_start_q;
	assign delay = run_start_q - rstamp_q[slot_q];
	assign rem_sh = {rem_q, dividend_q[38]};
	assign rem_sub = rem_sh - {1'b0, divisor_q};

	always_comb begin
		st.kind = kind_q;
		st.srch_done = found_q || ptr_end;
		st.emit_done = (ptr_q + CW'(1) >= count_q);
		st.empty = (count_q == '0);
		st.div_done = (dcnt_q == 6'd38);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marked_q <= '0;
			count_q <= '0;
			run_start_q <= '0;
			idle_sum_q <= '0;
			ivl_start_q <= '0;
			last_q_q <= '0;
			kind_q <= K_NONE;
			hdl_q <= '0;
			now_q <= '0;
			ptr_q <= '0;
			found_q <= 1'b0;
			slot_q <= '0;
			dividend_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			divisor_q <= '0;
			dcnt_q <= '0;
			dzero_q <= 1'b0;
			strobe <= 1'b0;
			entry_index <= '0;
			entry_handle <= '0;
			run_total <= '0;
			worst_delay <= '0;
			interval_begin <= '0;
			snapshot_time <= '0;
			idle_percent <= '0;
			entry_valid <= 1'b0;
			last <= 1'b0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				handle_q[i] <= '0;
				total_q[i] <= '0;
				rstamp_q[i] <= '0;
				worst_q[i] <= '0;
			end
		end else begin
			strobe <= 1'b0;
			if (cmd.load) begin
				kind_q <= kind_t'(kind);
				hdl_q <= task_handle;
				now_q <= timestamp;
			end
			if (cmd.srch_init) begin
				ptr_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.do_reg && hdl_q != '0 && count_q < CAP) begin
				handle_q[count_q[IW-1:0]] <= hdl_q;
				count_q <= count_q + CW'(1);
			end
			if (cmd.run_beg) run_start_q <= now_q;
			if (cmd.srch_step && !found_q && !ptr_end) begin
				if (hdl_q != '0 && handle_q[ptr_idx] == hdl_q) begin
					found_q <= 1'b1;
					slot_q <= ptr_idx;
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (cmd.set_ready && found_q) begin
				rstamp_q[slot_q] <= now_q;
				marked_q[slot_q] <= 1'b1;
			end
			if (cmd.close && found_q) begin
				if (marked_q[slot_q]) begin
					if (delay > worst_q[slot_q]) worst_q[slot_q] <= delay;
				end else begin
					idle_sum_q <= idle_sum_q + elapsed;
				end
				total_q[slot_q] <= total_q[slot_q] + {32'd0, elapsed};
			end
			if (cmd.emit_init) ptr_q <= '0;
			if (cmd.emit_step) begin
				strobe <= 1'b1;
				entry_index <= 4'(ptr_q);
				entry_handle <= handle_q[ptr_idx];
				run_total <= total_q[ptr_idx];
				worst_delay <= worst_q[ptr_idx];
				interval_begin <= ivl_start_q;
				snapshot_time <= now_q;
				idle_percent <= '0;
				entry_valid <= 1'b1;
				last <= (ptr_q + CW'(1) >= count_q);
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.emit_empty) begin
				strobe <= 1'b1;
				entry_index <= '0;
				entry_handle <= '0;
				run_total <= '0;
				worst_delay <= '0;
				interval_begin <= ivl_start_q;
				snapshot_time <= now_q;
				idle_percent <= '0;
				entry_valid <= 1'b0;
				last <= 1'b1;
			end
			if (cmd.clr) begin
				marked_q <= '0;
				for (int i = 0; i < TASK_SLOTS; i++) begin
					total_q[i] <= '0;
					rstamp_q[i] <= '0;
					worst_q[i] <= '0;
				end
				ivl_start_q <= now_q;
				run_start_q <= now_q;
			end
			if (cmd.div_init) begin
				// idle*100 = idle*64 + idle*32 + idle*4
				dividend_q <= {1'b0, idle_sum_q, 6'd0} + {2'd0, idle_sum_q, 5'd0}
					+ {5'd0, idle_sum_q, 2'd0};
				divisor_q <= now_q - last_q_q;
				dzero_q <= (now_q == last_q_q);
				rem_q <= '0;
				quot_q <= '0;
				dcnt_q <= '0;
				last_q_q <= now_q;
				idle_sum_q <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 6'd1;
				dividend_q <= {dividend_q[37:0], 1'b0};
				// remainder stays below a nonzero divisor, so 32 bits hold it
				if (rem_sh >= {1'b0, divisor_q}) begin
					rem_q <= rem_sub[31:0];
					quot_q <= {quot_q[37:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quot_q <= {quot_q[37:0], 1'b0};
				end
			end
			if (cmd.div_out) begin
				strobe <= 1'b1;
				entry_index <= '0;
				entry_handle <= '0;
				run_total <= '0;
				worst_delay <= '0;
				interval_begin <= '0;
				snapshot_time <= '0;
				entry_valid <= 1'b0;
				last <= 1'b1;
				if (dzero_q) idle_percent <= '0;
				else if (quot_q > 39'(PERCENT)) idle_percent <= PERCENT;
				else idle_percent <= quot_q[6:0];
			end
		end
	end

endmodule

### src/task_runtime_accounting.sv
// Top level of the task run-time accounting block.
// Depends on tra_pkg, tra_ctrl, tra_dp.
//
// Usage: an event transaction (kind, task_handle, timestamp) is taken when
// start is high and busy is low. Results come on the entry_* and related
// ports, each valid for exactly one cycle while strobe is high; the
// receiver must take them then, it cannot stall the block.
// Kinds: register, ready, run start, run end, snapshot, reset, idle query.
// Steps per transaction (the slot search walks one table slot a cycle):
//   register, run start, undefined kind: dispatched with no slot search
//   ready, run end: slot search, then the found slot is updated
//   reset: as run end plus the interval clear; snapshot: as reset plus one
//     result per registered task, one per cycle, or one empty result
//   idle query: a restoring divider takes one quotient bit a cycle over
//     the 39-bit product idle*100
// busy is high for the whole of a transaction. Reset clears the task table,
// accumulators and counters immediately; the block is ready after reset.
module task_runtime_accounting import tra_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] task_handle,
	input  logic [31:0] timestamp,
	output logic        strobe,
	output logic [3:0]  entry_index,
	output logic [31:0] entry_handle,
	output logic [63:0] run_total,
	output logic [31:0] worst_delay,
	output logic [31:0] interval_begin,
	output logic [31:0] snapshot_time,
	output logic [6:0]  idle_percent,
	output logic        entry_valid,
	output logic        last
);

	cmd_t  cmd;
	stat_t st;

	tra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.st(st), .cmd(cmd)
	);

	tra_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.kind(kind), .task_handle(task_handle), .timestamp(timestamp),
		.strobe(strobe), .entry_index(entry_index),
		.entry_handle(entry_handle), .run_total(run_total),
		.worst_delay(worst_delay), .interval_begin(interval_begin),
		.snapshot_time(snapshot_time), .idle_percent(idle_percent),
		.entry_valid(entry_valid), .last(last)
	);

endmodule

### sim/tra_checker.sv
// Checker for the task run-time accounting block: watches the event and
// result channels, predicts results and compares them. Depends on tra_pkg.
`timescale 1ns / 1ps
module tra_checker import tra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] task_handle,
	input  logic [31:0] timestamp,
	input  logic        strobe,
	input  logic [3:0]  entry_index,
	input  logic [31:0] entry_handle,
	input  logic [63:0] run_total,
	input  logic [31:0] worst_delay,
	input  logic [31:0] interval_begin,
	input  logic [31:0] snapshot_time,
	input  logic [6:0]  idle_percent,
	input  logic        entry_valid,
	input  logic        last,
	output int          fail_count,
	output int          pending
);
	localparam int SLOTS = TASK_SLOTS_DEF;

	typedef struct packed {
		logic [3:0]  index;
		logic [31:0] handle;
		logic [63:0] total;
		logic [31:0] worst;
		logic [31:0] ibegin;
		logic [31:0] stime;
		logic [6:0]  pct;
		logic        valid;
		logic        lst;
	} report_t;

	report_t     report_q[$];
	logic [31:0] handles[SLOTS];
	logic [63:0] totals[SLOTS];
	logic [31:0] ready_at[SLOTS];
	logic [31:0] worst_d[SLOTS];
	logic        marked[SLOTS];
	int          n_tasks;
	logic [31:0] run_t0, idle_acc, iv_start, q_time;

	assign pending = report_q.size();

	function automatic int lookup(logic [31:0] h);
		if (h == 0)
			return -1;
		for (int i = 0; i < n_tasks; i++)
			if (handles[i] == h)
				return i;
		return -1;
	endfunction

	task automatic charge_run(logic [31:0] h, logic [31:0] now);
		int s;
		logic [31:0] len, d;
		s = lookup(h);
		len = now - run_t0;
		if (s >= 0) begin
			if (marked[s]) begin
				d = run_t0 - ready_at[s];
				if (d > worst_d[s])
					worst_d[s] = d;
			end else begin
				idle_acc = idle_acc + len;
			end
			totals[s] = totals[s] + 64'(len);
		end
	endtask

	task automatic new_interval(logic [31:0] now);
		for (int i = 0; i < SLOTS; i++) begin
			totals[i] = 0;
			ready_at[i] = 0;
			worst_d[i] = 0;
			marked[i] = 0;
		end
		iv_start = now;
		run_t0 = now;
	endtask

	task automatic predict(kind_t k, logic [31:0] h, logic [31:0] now);
		int s;
		logic [31:0] diff;
		logic [63:0] p;
		report_t r;
		case (k)
			K_REGISTER: begin
				if (h != 0 && n_tasks < SLOTS - 1) begin
					handles[n_tasks] = h;
					n_tasks++;
				end
			end
			K_READY: begin
				s = lookup(h);
				if (s >= 0) begin
					ready_at[s] = now;
					marked[s] = 1;
				end
			end
			K_RUN_BEG: run_t0 = now;
			K_RUN_END: charge_run(h, now);
			K_SNAPSHOT: begin
				charge_run(h, now);
				if (n_tasks == 0) begin
					r = '0;
					r.ibegin = iv_start;
					r.stime = now;
					r.lst = 1;
					report_q.push_back(r);
				end
				for (int i = 0; i < n_tasks; i++) begin
					r = '0;
					r.index = 4'(i);
					r.handle = handles[i];
					r.total = totals[i];
					r.worst = worst_d[i];
					r.ibegin = iv_start;
					r.stime = now;
					r.valid = 1;
					r.lst = (i + 1 == n_tasks);
					report_q.push_back(r);
				end
				new_interval(now);
			end
			K_RESET: begin
				charge_run(h, now);
				new_interval(now);
			end
			K_IDLE_Q: begin
				diff = now - q_time;
				q_time = now;
				p = 0;
				if (diff != 0) begin
					p = (64'(idle_acc) * 64'(PERCENT)) / 64'(diff);
					if (p > 64'(PERCENT))
						p = 64'(PERCENT);
				end
				idle_acc = 0;
				r = '0;
				r.pct = p[6:0];
				r.lst = 1;
				report_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				handles[i] = 0;
			n_tasks = 0;
			idle_acc = 0;
			q_time = 0;
			new_interval(0);
			iv_start = 0;
			run_t0 = 0;
			report_q.delete();
			fail_count <= 0;
		end else begin
			// results first: a transaction taken now cannot answer this cycle
			if (strobe) begin
				got = {entry_index, entry_handle, run_total, worst_delay,
					interval_begin, snapshot_time, idle_percent, entry_valid, last};
				if (report_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = report_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: exp %h got %h", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				predict(kind_t'(kind), task_handle, timestamp);
		end
	end
endmodule

### sim/tb_task_runtime_accounting.sv
// Top of the task run-time accounting testbench: clock, reset, event
// stimulus, watchdog and verdict. Depends on tra_pkg, tra_checker, the block.
`timescale 1ns / 1ps
module tb_task_runtime_accounting;
	import tra_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [2:0]  kind = K_NONE;
	logic [31:0] task_handle = 0;
	logic [31:0] timestamp = 0;
	logic        busy, strobe, entry_valid, last;
	logic [3:0]  entry_index;
	logic [31:0] entry_handle, worst_delay, interval_begin, snapshot_time;
	logic [63:0] run_total;
	logic [6:0]  idle_percent;
	int          fail_count, pending;
	int          stall_cycles = 0;

	// small pool of handles so lookups mostly hit
	logic [31:0] pool[8];
	logic [31:0] clock_now = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	task_runtime_accounting u_dut (.*);
	tra_checker u_chk (.*);

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one event transaction; start stays high until a gap drops it
	task automatic send(kind_t k, logic [31:0] h, logic [31:0] ts);
		kind <= k;
		task_handle <= h;
		timestamp <= ts;
		start <= 1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// time advances mostly forward, sometimes jumps (wrap cases)
	function automatic logic [31:0] tick();
		if ($urandom_range(0, 15) == 0)
			clock_now = $urandom;
		else
			clock_now = clock_now + $urandom_range(0, 5000);
		return clock_now;
	endfunction

	function automatic logic [31:0] pick();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return pool[$urandom_range(0, 7)];
	endfunction

	task automatic random_gap();
		if ($urandom_range(0, 2) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			pool[i] = $urandom | 32'h1;
		pool[7] = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty snapshot, zero-time idle query, zero handle
		send(K_SNAPSHOT, 32'h1, 32'h0);
		send(K_IDLE_Q, 32'h0, 32'h0);
		send(K_REGISTER, 32'h0, 32'h10);
		send(K_NONE, 32'h5, 32'h20);
		// register pool twice over: duplicates and the full-table refusal
		for (int i = 0; i < 16; i++)
			send(K_REGISTER, pool[i % 8], 32'(i));
		send(K_READY, pool[1], 32'hFFFF_FFF0);
		send(K_RUN_BEG, 32'h0, 32'h0000_0010); // delay wraps
		send(K_RUN_END, pool[1], 32'hFFFF_FFFF);
		send(K_RUN_END, pool[1], 32'h0000_0020); // repeated run end
		send(K_RUN_END, pool[0], 32'h0000_0100); // idle task
		send(K_RUN_END, 32'hDEAD_0000, 32'h200); // unknown handle
		send(K_IDLE_Q, 32'h0, 32'h0000_0101); // idle share below the cap
		send(K_SNAPSHOT, pool[7], 32'hFFFF_FFFF);
		send(K_RESET, pool[2], 32'h1000);
		send(K_IDLE_Q, 32'h0, 32'h1100);

		// random: mostly ready/run start/run end cycles, occasional reports
		for (int n = 0; n < 200; n++) begin
			random_gap();
			case ($urandom_range(0, 19))
				0: send(K_REGISTER, pick(), tick());
				1: send(K_SNAPSHOT, pick(), tick());
				2: send(K_IDLE_Q, pick(), tick());
				3: send(K_RESET, pick(), tick());
				4: send(kind_t'($urandom_range(0, 7)), $urandom, $urandom);
				5, 6, 7, 8: send(K_READY, pick(), tick());
				9, 10, 11, 12, 13: send(K_RUN_BEG, pick(), tick());
				default: send(K_RUN_END, pick(), tick());
			endcase
		end
		send(K_SNAPSHOT, pool[0], tick());
		start <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
